### design/lsws_pkg.sv
// ----------------------------------------------------------------------------
// lsws_pkg
// Shared types and constants for the longest subarray with sum block.
// ----------------------------------------------------------------------------
package lsws_pkg;

   localparam int TARGET_WIDTH  = 32;
   localparam int LEN_OUT_WIDTH = 9;

   typedef struct packed {
      logic valid;
      logic first;
   } scan_ctl_type;

endpackage

### design/lsws_req_if.sv
// ----------------------------------------------------------------------------
// lsws_req_if
// Element input channel: valid/ready handshake with value and last flag.
// ----------------------------------------------------------------------------
interface lsws_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] element_value;
   logic                          is_last;

   modport source (output valid, output element_value, output is_last, input ready);
   modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

### design/lsws_rsp_if.sv
// ----------------------------------------------------------------------------
// lsws_rsp_if
// Result channel: valid/ready handshake with run length and overflow flag.
// ----------------------------------------------------------------------------
interface lsws_rsp_if;
   import lsws_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [LEN_OUT_WIDTH-1:0] longest_length;
   logic                     elements_dropped;

   modport source (output valid, output longest_length, output elements_dropped,
                   input ready);
   modport sink   (input valid, input longest_length, input elements_dropped,
                   output ready);
endinterface

### design/lsws_ram.sv
// ----------------------------------------------------------------------------
// lsws_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsws_ram #(
   parameter int WIDTH      = 32,
   parameter int DEPTH      = 256,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### design/lsws_scan.sv
// ----------------------------------------------------------------------------
// lsws_scan
// Read sequencer: walks every start position and every end position from
// it onward, issuing one store read per cycle with the run length so far.
// ----------------------------------------------------------------------------
module lsws_scan #(
   parameter int ADDR_WIDTH = 8,
   parameter int LEN_WIDTH  = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ADDR_WIDTH-1:0]      last_index,
   output logic                       busy,
   output lsws_pkg::scan_ctl_type     issue_ctl,
   output logic [ADDR_WIDTH-1:0]      rd_addr,
   output logic [LEN_WIDTH-1:0]       issue_len
);
   import lsws_pkg::*;

   logic                  busy_ff, busy_in;
   logic [ADDR_WIDTH-1:0] start_ff, start_in;
   logic [ADDR_WIDTH-1:0] end_ff, end_in;
   logic [LEN_WIDTH-1:0]  len_ff, len_in;

   always_comb begin
      busy_in  = busy_ff;
      start_in = start_ff;
      end_in   = end_ff;
      len_in   = len_ff;
      if (start) begin
         busy_in  = 1'b1;
         start_in = '0;
         end_in   = '0;
         len_in   = LEN_WIDTH'(1);
      end else if (busy_ff) begin
         if (end_ff == last_index) begin
            if (start_ff == last_index) begin
               busy_in = 1'b0;
            end else begin
               start_in = start_ff + ADDR_WIDTH'(1);
               end_in   = start_ff + ADDR_WIDTH'(1);
               len_in   = LEN_WIDTH'(1);
            end
         end else begin
            end_in = end_ff + ADDR_WIDTH'(1);
            len_in = len_ff + LEN_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      start_ff <= start_in;
      end_ff   <= end_in;
      len_ff   <= len_in;
   end

   assign busy            = busy_ff;
   assign issue_ctl.valid = busy_ff;
   assign issue_ctl.first = (len_ff == LEN_WIDTH'(1));
   assign rd_addr         = end_ff;
   assign issue_len       = len_ff;
endmodule

### design/lsws_accum.sv
// ----------------------------------------------------------------------------
// lsws_accum
// Running sum and match stage: aligns issued reads with store data, keeps
// the run total and records the longest run that hits the target.
// ----------------------------------------------------------------------------
module lsws_accum #(
   parameter int VALUE_WIDTH = 32,
   parameter int SUM_WIDTH   = 42,
   parameter int LEN_WIDTH   = 9
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   clear,
   input  lsws_pkg::scan_ctl_type                 issue_ctl,
   input  logic [LEN_WIDTH-1:0]                   issue_len,
   input  logic [VALUE_WIDTH-1:0]                 rd_data,
   input  logic signed [lsws_pkg::TARGET_WIDTH-1:0] target_sum,
   output logic                                   busy,
   output logic [LEN_WIDTH-1:0]                   best_length
);
   import lsws_pkg::*;

   scan_ctl_type          rd_ctl_ff;
   logic [LEN_WIDTH-1:0]  rd_len_ff;
   logic                  acc_valid_ff;
   logic [LEN_WIDTH-1:0]  acc_len_ff;
   logic [SUM_WIDTH-1:0]  sum_ff, sum_in;
   logic [LEN_WIDTH-1:0]  best_ff, best_in;
   logic [SUM_WIDTH-1:0]  data_ext;
   logic [SUM_WIDTH-1:0]  target_ext;

   assign data_ext   = {{(SUM_WIDTH-VALUE_WIDTH){rd_data[VALUE_WIDTH-1]}}, rd_data};
   assign target_ext = {{(SUM_WIDTH-TARGET_WIDTH){target_sum[TARGET_WIDTH-1]}},
                        target_sum};

   always_comb begin
      sum_in = sum_ff;
      if (rd_ctl_ff.valid) begin
         sum_in = (rd_ctl_ff.first ? '0 : sum_ff) + data_ext;
      end
   end

   always_comb begin
      best_in = best_ff;
      if (clear) begin
         best_in = '0;
      end else if (acc_valid_ff && (sum_ff == target_ext) && (acc_len_ff > best_ff)) begin
         best_in = acc_len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ctl_ff    <= '0;
         acc_valid_ff <= 1'b0;
         best_ff      <= '0;
      end else begin
         rd_ctl_ff    <= issue_ctl;
         acc_valid_ff <= rd_ctl_ff.valid;
         best_ff      <= best_in;
      end
      rd_len_ff  <= issue_len;
      acc_len_ff <= rd_len_ff;
      sum_ff     <= sum_in;
   end

   assign busy        = rd_ctl_ff.valid | acc_valid_ff;
   assign best_length = best_ff;
endmodule

### design/longest_subarray_with_sum.sv
// ----------------------------------------------------------------------------
// longest_subarray_with_sum
// Finds the longest contiguous run of loaded elements whose sum equals the
// configured target.
// ----------------------------------------------------------------------------
// Elements load at one transfer per cycle into an element RAM of MAX_ELEMENTS
// entries; elements past capacity are dropped and flagged. The transfer marked
// last starts the search, which reads the RAM once per cycle for every
// (start, end) pair of the stored elements and then drains the pipeline,
// during which no element is taken. Sums are exact (the accumulator is
// wide enough for any run). The result sits in an output register, so
// loading of the next sequence may begin while it waits to be taken.
module longest_subarray_with_sum #(
   parameter int MAX_ELEMENTS = 256,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   lsws_req_if.sink                                 req_chan,
   lsws_rsp_if.source                               rsp_chan,
   input  logic                                     csr_write_enable,
   input  logic signed [lsws_pkg::TARGET_WIDTH-1:0] csr_write_data
);
   import lsws_pkg::*;

   localparam int ADDR_WIDTH = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_WIDTH  = $clog2(MAX_ELEMENTS + 1);
   localparam int LEN_WIDTH  = CNT_WIDTH;
   localparam int WIDE_VALUE = (VALUE_WIDTH > TARGET_WIDTH) ? VALUE_WIDTH : TARGET_WIDTH;
   localparam int SUM_RAW    = WIDE_VALUE + CNT_WIDTH + 1;
   localparam int SUM_WIDTH  = (SUM_RAW > 64) ? 64 : SUM_RAW;

   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [CNT_WIDTH-1:0]      count_ff, count_in;
   logic                      overflow_ff, overflow_in;
   logic                      start_ff, start_in;
   logic signed [TARGET_WIDTH-1:0] target_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LEN_OUT_WIDTH-1:0]  rsp_len_ff, rsp_len_in;
   logic                      rsp_drop_ff, rsp_drop_in;

   logic                      req_xfer;
   logic                      store_full;
   logic                      wr_en;
   logic [ADDR_WIDTH-1:0]     last_index;
   logic                      scan_busy;
   scan_ctl_type              issue_ctl;
   logic [ADDR_WIDTH-1:0]     rd_addr;
   logic [LEN_WIDTH-1:0]      issue_len;
   logic [VALUE_WIDTH-1:0]    rd_data;
   logic                      accum_busy;
   logic [LEN_WIDTH-1:0]      best_length;

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_xfer       = req_chan.valid & req_chan.ready;
   assign store_full     = (count_ff == CNT_WIDTH'(MAX_ELEMENTS));
   assign wr_en          = req_xfer & ~store_full;
   assign last_index     = ADDR_WIDTH'(count_ff - CNT_WIDTH'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_len_in   = rsp_len_ff;
      rsp_drop_in  = rsp_drop_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (store_full) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_WIDTH'(1);
               end
               if (req_chan.is_last) begin
                  start_in = 1'b1;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (!start_ff && !scan_busy) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!accum_busy && (!rsp_valid_ff || rsp_chan.ready)) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = LEN_OUT_WIDTH'(best_length);
               rsp_drop_in  = overflow_ff;
               count_in     = '0;
               overflow_in  = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         start_ff     <= 1'b0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            target_ff <= csr_write_data;
         end
      end
      rsp_len_ff  <= rsp_len_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.longest_length   = rsp_len_ff;
   assign rsp_chan.elements_dropped = rsp_drop_ff;

   lsws_ram #(
      .WIDTH      (VALUE_WIDTH),
      .DEPTH      (MAX_ELEMENTS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_WIDTH'(count_ff)),
      .wr_data (req_chan.element_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lsws_scan #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .LEN_WIDTH  (LEN_WIDTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff),
      .last_index (last_index),
      .busy       (scan_busy),
      .issue_ctl  (issue_ctl),
      .rd_addr    (rd_addr),
      .issue_len  (issue_len)
   );

   lsws_accum #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .SUM_WIDTH   (SUM_WIDTH),
      .LEN_WIDTH   (LEN_WIDTH)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .clear       (start_ff),
      .issue_ctl   (issue_ctl),
      .issue_len   (issue_len),
      .rd_data     (rd_data),
      .target_sum  (target_ff),
      .busy        (accum_busy),
      .best_length (best_length)
   );
endmodule

### dv/lsws_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsws_checker
// Watches the element and result channels and the target register port,
// works out the longest matching run for each sequence on its own, and
// compares every result transfer with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module lsws_checker #(
   parameter int MAX_ELEMENTS = 256,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   lsws_req_if                                      req_mon,
   lsws_rsp_if                                      rsp_mon,
   input  logic                                     csr_write_enable,
   input  logic signed [lsws_pkg::TARGET_WIDTH-1:0] csr_write_data,
   output int                                       fail_count,
   output int                                       pending_results,
   output int                                       elements_seen,
   output int                                       results_seen,
   output int                                       matches_seen,
   output int                                       drops_seen
);
   import lsws_pkg::*;

   typedef struct packed {
      logic [LEN_OUT_WIDTH-1:0] longest_length;
      logic                     elements_dropped;
   } run_result_type;

   logic signed [VALUE_WIDTH-1:0]  element_store [MAX_ELEMENTS];
   logic signed [TARGET_WIDTH-1:0] target_sum;
   int                             stored_count;
   logic                           overflow_seen;
   run_result_type                 expected_runs [$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
      elements_seen   = 0;
      results_seen    = 0;
      matches_seen    = 0;
      drops_seen      = 0;
      stored_count    = 0;
      overflow_seen   = 1'b0;
      target_sum      = '0;
   end

   function automatic logic [LEN_OUT_WIDTH-1:0] longest_match_length(input int count);
      longint total;
      int     best;
      best = 0;
      for (int s = 0; s < count; s++) begin
         total = 0;
         for (int e = s; e < count; e++) begin
            total += longint'(element_store[e]);
            if (total == longint'(target_sum) && (e - s + 1) > best) begin
               best = e - s + 1;
            end
         end
      end
      return best[LEN_OUT_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin
      run_result_type want;
      if (reset) begin
         stored_count  = 0;
         overflow_seen = 1'b0;
         target_sum    = '0;
         expected_runs.delete();
      end else begin
         if (csr_write_enable) begin
            target_sum = csr_write_data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (expected_runs.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: result with nothing outstanding: len %0d dropped %0b",
                           $realtime, rsp_mon.longest_length, rsp_mon.elements_dropped);
               end
            end else begin
               want = expected_runs.pop_front();
               if (rsp_mon.longest_length !== want.longest_length ||
                   rsp_mon.elements_dropped !== want.elements_dropped) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: expected len %0d drop %0b, got len %0d drop %0b",
                              $realtime, want.longest_length, want.elements_dropped,
                              rsp_mon.longest_length, rsp_mon.elements_dropped);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            elements_seen++;
            if (stored_count < MAX_ELEMENTS) begin
               element_store[stored_count] = req_mon.element_value;
               stored_count++;
            end else begin
               overflow_seen = 1'b1;
            end
            if (req_mon.is_last) begin
               want.longest_length   = longest_match_length(stored_count);
               want.elements_dropped = overflow_seen;
               if (want.longest_length != 0) begin
                  matches_seen++;
               end
               if (overflow_seen) begin
                  drops_seen++;
               end
               expected_runs.push_back(want);
               stored_count  = 0;
               overflow_seen = 1'b0;
            end
         end
      end
      pending_results = expected_runs.size();
   end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for longest_subarray_with_sum: drives element sequences in
// bursts under a stalling result receiver, changes the target between
// phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
   import lsws_pkg::*;

   localparam int MAX_ELEMENTS   = 256;
   localparam int VALUE_WIDTH    = 32;
   localparam int RANDOM_ITEMS   = 80;
   localparam int WATCHDOG_LIMIT = 150000;
   localparam int SETTLE_CYCLES  = 8;

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7fff_ffff;

   logic                           clock;
   logic                           reset;
   logic                           csr_write_enable;
   logic signed [TARGET_WIDTH-1:0] csr_write_data;

   int fail_count;
   int pending_results;
   int elements_seen;
   int results_seen;
   int matches_seen;
   int drops_seen;
   int idle_cycles;
   int burst_left;
   int target_writes;

   logic signed [VALUE_WIDTH-1:0] run_values [$];

   lsws_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_chan ();
   lsws_rsp_if                              rsp_chan ();

   longest_subarray_with_sum #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   lsws_checker #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .elements_seen    (elements_seen),
      .results_seen     (results_seen),
      .matches_seen     (matches_seen),
      .drops_seen       (drops_seen)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // receiver stall pattern, reshuffled at random among four kinds
   initial begin
      logic [15:0] stall_pattern;
      int          slot;
      rsp_chan.ready = 1'b0;
      stall_pattern  = 16'hffff;
      slot           = 0;
      forever begin
         @(negedge clock);
         if (slot % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = 16'hffff;
               1: stall_pattern = 16'($urandom) | 16'h0001;
               2: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
               default: stall_pattern = 16'h0001 << $urandom_range(0, 3) | 16'h8000;
            endcase
         end
         rsp_chan.ready <= stall_pattern[slot % 16];
         slot++;
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic signed [VALUE_WIDTH-1:0] pick_element(input int mode);
      case (mode)
         0: return VALUE_WIDTH'(int'($urandom_range(0, 8)) - 4);
         1: begin
            case ($urandom_range(0, 9))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return -1;
               3: return 0;
               4: return $urandom;
               default: return VALUE_WIDTH'(int'($urandom_range(0, 8)) - 4);
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [TARGET_WIDTH-1:0] pick_target();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return VALUE_MIN;
         2: return VALUE_MAX;
         3: return $urandom;
         default: return TARGET_WIDTH'(int'($urandom_range(0, 16)) - 8);
      endcase
   endfunction

   // one element transfer; returns at a falling edge, possibly after a burst gap
   task automatic send_element(input logic signed [VALUE_WIDTH-1:0] value, input logic last);
      int gap;
      req_chan.valid         <= 1'b1;
      req_chan.element_value <= value;
      req_chan.is_last       <= last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         gap        = $urandom_range(0, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic send_run();
      foreach (run_values[i]) begin
         send_element(run_values[i], i == run_values.size() - 1);
      end
      run_values.delete();
   endtask

   // target changes only with the block idle and every result collected
   task automatic write_target(input logic signed [TARGET_WIDTH-1:0] value);
      req_chan.valid <= 1'b0;
      wait (pending_results == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      target_writes++;
   endtask

   initial begin
      int     len;
      int     mode;
      int     random_items;
      longint run_sum;
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_write_data         = '0;
      req_chan.valid         = 1'b0;
      req_chan.element_value = '0;
      req_chan.is_last       = 1'b0;
      idle_cycles            = 0;
      burst_left             = 1;
      target_writes          = 0;
      random_items           = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero target from reset, then the extremes
      run_values = '{32'sd0};
      send_run();
      run_values = '{32'sd5};
      send_run();
      run_values = '{VALUE_MAX, VALUE_MIN, 32'sd1};
      send_run();
      run_values = '{-32'sd1, 32'sd1, -32'sd1, 32'sd1};
      send_run();
      write_target(VALUE_MIN);
      run_values = '{VALUE_MIN};
      send_run();
      run_values = '{VALUE_MIN, -32'sd1, 32'sd1};
      send_run();
      write_target(VALUE_MAX);
      run_values = '{VALUE_MAX, 32'sd0, 32'sd0};
      send_run();
      run_values = '{VALUE_MAX, VALUE_MAX, VALUE_MIN + 32'sd1};
      send_run();
      write_target(32'sd3);
      run_values = '{32'sd1, 32'sd2, 32'sd5, -32'sd5, 32'sd0};
      send_run();

      // random phases of short sequences
      while (random_items < RANDOM_ITEMS) begin
         write_target(pick_target());
         repeat ($urandom_range(3, 8)) begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
            mode = $urandom_range(0, 5);
            mode = (mode < 4) ? 0 : mode - 3;
            repeat (len) run_values.push_back(pick_element(mode));
            random_items += len;
            send_run();
         end
      end

      // full store, with the whole run matching
      run_sum = 0;
      repeat (MAX_ELEMENTS) run_values.push_back(pick_element(0));
      foreach (run_values[i]) run_sum += longint'(run_values[i]);
      write_target(run_sum[TARGET_WIDTH-1:0]);
      send_run();

      // past capacity: trailing elements and the last one are dropped
      run_sum = 0;
      repeat (MAX_ELEMENTS) run_values.push_back(pick_element(0));
      foreach (run_values[i]) run_sum += longint'(run_values[i]);
      repeat ($urandom_range(1, 6)) run_values.push_back(pick_element(2));
      write_target(run_sum[TARGET_WIDTH-1:0]);
      send_run();

      req_chan.valid <= 1'b0;
      wait (pending_results == 0);
      repeat (20) @(posedge clock);
      $display("covered %0d elements in %0d sequences over %0d target settings",
               elements_seen, results_seen, target_writes);
      $display("%0d sequences found a matching run, %0d had elements dropped",
               matches_seen, drops_seen);
      if (fail_count + pending_results == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
